// ----- sv/ansi_text_terminal_screen_assert.svh -----
// assertion macros for the ansi text terminal screen
// expects clk and arst_n in the scope of use
`ifndef ANSI_TEXT_TERMINAL_SCREEN_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_SCREEN_ASSERT_SVH

// condition implies consequence in the same cycle
`define ATS_ASSERT_IMP(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("ats assertion failed");

// condition implies consequence in the next cycle
`define ATS_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("ats assertion failed");

`endif

// ----- sv/ats_pkg.sv -----
// types, constants and helpers for the ansi text terminal screen
// used by ats_csi_param and the screen top module; no dependencies
`default_nettype none
package ats_pkg;
	localparam int ROWS_DEF = 24;
	localparam int COLS_DEF = 80;
	localparam int SEQ_MAX_DEF = 24;
	localparam int TAB_WIDTH_DEF = 8;
	localparam int PAR_W = 14;
	localparam int SEQ_W = 5;
	localparam logic [PAR_W-1:0] PARAM_LIMIT = 14'd9999;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CSI_FIRST = 8'h40;
	localparam logic [7:0] CSI_LAST = 8'h7E;

	localparam logic [7:0] FIN_CUU = 8'h41; // A
	localparam logic [7:0] FIN_CUD = 8'h42; // B
	localparam logic [7:0] FIN_CUF = 8'h43; // C
	localparam logic [7:0] FIN_CUB = 8'h44; // D
	localparam logic [7:0] FIN_CHA = 8'h47; // G
	localparam logic [7:0] FIN_VPA = 8'h64; // d
	localparam logic [7:0] FIN_CUP = 8'h48; // H
	localparam logic [7:0] FIN_HVP = 8'h66; // f
	localparam logic [7:0] FIN_ED = 8'h4A;  // J
	localparam logic [7:0] FIN_EL = 8'h4B;  // K
	localparam logic [7:0] FIN_DCH = 8'h50; // P
	localparam logic [7:0] FIN_SCP = 8'h73; // s
	localparam logic [7:0] FIN_RCP = 8'h75; // u

	localparam logic [1:0] MODE_GROUND = 2'd0;
	localparam logic [1:0] MODE_ESC = 2'd1;
	localparam logic [1:0] MODE_CSI = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic [1:0] parse_mode;
	} rsp_t;

	typedef struct packed {
		logic       clear;
		logic       keep;
		logic [7:0] ch;
	} par_cmd_t;

	typedef struct packed {
		logic [PAR_W-1:0] v;
		logic [PAR_W-1:0] v0;
		logic [PAR_W-1:0] w;
	} csi_par_t;

	// 1-based position to 0-based, clamped below lim
	function automatic logic [PAR_W-1:0] place(input logic [PAR_W-1:0] v,
			input logic [PAR_W-1:0] lim);
		logic [PAR_W-1:0] p;
		p = (v != '0) ? v - 1'b1 : '0;
		return (p < lim) ? p : lim - 1'b1;
	endfunction
endpackage
`default_nettype wire

// ----- sv/ats_mem.sv -----
// screen character store: one write port, one registered read port
// no dependencies
`default_nettype none
module ats_mem #(
	parameter int DEPTH = 1920,
	parameter int AW = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/ats_csi_param.sv -----
// control sequence parameter collector: two decimal fields, saturating
// depends on ats_pkg
`default_nettype none
module ats_csi_param #(
	parameter int SEQ_MAX = ats_pkg::SEQ_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ats_pkg::par_cmd_t cmd,
	output ats_pkg::csi_par_t      par
);
	localparam logic [ats_pkg::SEQ_W-1:0] SEQ_LIM = ats_pkg::SEQ_W'(SEQ_MAX);

	logic [ats_pkg::PAR_W-1:0] p1_q, p2_q;
	logic [1:0]                present_q;
	logic [1:0]                idx_q;
	logic                      stopped_q;
	logic [ats_pkg::SEQ_W-1:0] len_q;
	logic [ats_pkg::PAR_W-1:0] cur;
	logic [17:0]               nv;
	logic [ats_pkg::PAR_W-1:0] sat;
	logic                      digit;

	// next value of the current field
	always_comb begin
		cur = (idx_q == 2'd0) ? p1_q : p2_q;
		nv = 18'(cur) * 18'd10 + 18'(cmd.ch[3:0]);
		sat = (nv > 18'(ats_pkg::PARAM_LIMIT)) ? ats_pkg::PARAM_LIMIT
			: ats_pkg::PAR_W'(nv);
		digit = (cmd.ch >= ats_pkg::CH_ZERO) && (cmd.ch <= ats_pkg::CH_NINE);
	end

	// field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_q <= '0;
			p2_q <= '0;
			present_q <= '0;
			idx_q <= '0;
			stopped_q <= 1'b0;
			len_q <= '0;
		end else if (cmd.clear) begin
			p1_q <= '0;
			p2_q <= '0;
			present_q <= '0;
			idx_q <= '0;
			stopped_q <= 1'b0;
			len_q <= '0;
		end else if (cmd.keep && (len_q < SEQ_LIM)) begin
			len_q <= len_q + 1'b1;
			if (cmd.ch == ats_pkg::CH_SEMI) begin
				if (idx_q < 2'd2) begin
					idx_q <= idx_q + 1'b1;
				end
				stopped_q <= 1'b0;
			end else if (idx_q < 2'd2) begin
				present_q[idx_q[0]] <= 1'b1;
				if (!stopped_q) begin
					if (digit) begin
						if (idx_q == 2'd0) begin
							p1_q <= sat;
						end else begin
							p2_q <= sat;
						end
					end else begin
						stopped_q <= 1'b1;
					end
				end
			end
		end
	end

	// defaults for empty fields
	assign par.v = present_q[0] ? p1_q : ats_pkg::PAR_W'(1);
	assign par.v0 = present_q[0] ? p1_q : '0;
	assign par.w = present_q[1] ? p2_q : ats_pkg::PAR_W'(1);
endmodule
`default_nettype wire

// ----- sv/ansi_text_terminal_screen.sv -----
// ANSI text terminal screen: a ROWS x COLS character store driven by a host
// byte stream, with cursor motion, scrolling, erase and delete-character
// sequences; each item is a stream byte or a cell read and yields one result
// holding the cell (zero for bytes), the cursor and the parser mode. After
// reset a clearing pass fills the store with spaces and no item is taken. A
// plain byte goes through the execute and finish states to the result register,
// a read also through the read state; items are worked one at a time. A line
// feed on the bottom row copies the store up one row through its single read
// and write port; erase sequences write one cell per cycle over their span;
// delete-character copies and fills the cells from the cursor to the line end.
// depends on ats_pkg, ats_mem, ats_csi_param and the assertion header
`default_nettype none
`include "ansi_text_terminal_screen_assert.svh"
module ansi_text_terminal_screen #(
	parameter int ROWS = ats_pkg::ROWS_DEF,
	parameter int COLS = ats_pkg::COLS_DEF,
	parameter int SEQ_MAX = ats_pkg::SEQ_MAX_DEF,
	parameter int TAB_WIDTH = ats_pkg::TAB_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ats_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ats_pkg::rsp_t      rsp
);
	localparam int N = ROWS * COLS;
	localparam int AW = $clog2(N);
	localparam int AXW = AW + 1;
	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS);
	localparam int PW = ats_pkg::PAR_W;

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_RD, S_COPY, S_DRAIN, S_FILL, S_FIN
	} state_t;

	state_t             st_q, e_st;
	logic               boot_q;
	logic [RW-1:0]      row_q, srow_q, e_row;
	logic [CW-1:0]      col_q, scol_q, e_col;
	logic [1:0]         mode_q, e_mode;
	logic               e_save;
	ats_pkg::req_t      item_q;
	logic [7:0]         cell_q;
	logic [AXW-1:0]     cp_q, ce_q, off_q, cp_s1, fa_q, fe_q;
	logic [AXW-1:0]     e_cs, e_ce, e_off, e_fa, e_fe;
	logic               pend_s1;
	ats_pkg::rsp_t      out_q;
	logic               out_valid_q;

	logic [AXW-1:0]     base, colx, e_wa, e_ra;
	logic               e_we;
	logic               lf;
	logic [7:0]         ch;
	ats_pkg::par_cmd_t  pcmd;
	ats_pkg::csi_par_t  par;
	logic [PW:0]        sum_r, sum_c;
	logic [CW:0]        ncap, colinc;
	logic [CW:0]        n;
	logic [CW+4:0]      tab;

	logic               m_we;
	logic [AXW-1:0]     m_wa, m_ra;
	logic [7:0]         m_wd, rdata;

	ats_mem #(.DEPTH(N), .AW(AW)) u_mem (
		.clk(clk),
		.we(m_we),
		.waddr(m_wa[AW-1:0]),
		.wdata(m_wd),
		.raddr(m_ra[AW-1:0]),
		.rdata(rdata)
	);

	ats_csi_param #(.SEQ_MAX(SEQ_MAX)) u_par (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(pcmd),
		.par(par)
	);

	// decode of the held item
	always_comb begin
		ch = item_q.data_byte;
		base = AXW'(row_q) * AXW'(COLS);
		colx = AXW'(col_q);
		e_row = row_q;
		e_col = col_q;
		e_mode = mode_q;
		e_save = 1'b0;
		e_st = S_FIN;
		e_we = 1'b0;
		e_wa = base + colx;
		e_ra = AXW'(item_q.read_row) * AXW'(COLS) + AXW'(item_q.read_col);
		e_cs = '0;
		e_ce = '0;
		e_off = '0;
		e_fa = '0;
		e_fe = '0;
		pcmd = '0;
		pcmd.ch = ch;
		lf = 1'b0;
		sum_r = (PW+1)'(row_q) + (PW+1)'(par.v);
		sum_c = (PW+1)'(col_q) + (PW+1)'(par.v);
		ncap = (CW+1)'(COLS) - (CW+1)'(col_q);
		n = (par.v < PW'(ncap)) ? (CW+1)'(par.v) : ncap;
		// next tab stop from a chain of constant compares
		tab = (CW+5)'(TAB_WIDTH);
		for (int k = 1; k * TAB_WIDTH < COLS; k++) begin
			if ((CW+5)'(col_q) >= (CW+5)'(k * TAB_WIDTH)) begin
				tab = (CW+5)'((k + 1) * TAB_WIDTH);
			end
		end
		colinc = (CW+1)'(col_q) + 1'b1;
		if (item_q.req_type) begin
			if ((6'(item_q.read_row) < 6'(ROWS)) && (9'(item_q.read_col) < 9'(COLS))) begin
				e_st = S_RD;
			end
		end else if (!ch[7]) begin
			case (mode_q)
				ats_pkg::MODE_ESC: begin
					e_mode = ats_pkg::MODE_GROUND;
					if (ch == ats_pkg::CH_LBRACK) begin
						e_mode = ats_pkg::MODE_CSI;
						pcmd.clear = 1'b1;
					end else if (ch == ats_pkg::CH_SEVEN) begin
						e_save = 1'b1;
					end else if (ch == ats_pkg::CH_EIGHT) begin
						e_row = srow_q;
						e_col = scol_q;
					end
				end
				ats_pkg::MODE_CSI: begin
					if ((ch >= ats_pkg::CSI_FIRST) && (ch <= ats_pkg::CSI_LAST)) begin
						e_mode = ats_pkg::MODE_GROUND;
						case (ch)
							ats_pkg::FIN_CUU: begin
								e_row = (par.v >= PW'(row_q)) ? '0 : row_q - RW'(par.v);
							end
							ats_pkg::FIN_CUD: begin
								e_row = (sum_r > (PW+1)'(ROWS-1)) ? RW'(ROWS-1) : RW'(sum_r);
							end
							ats_pkg::FIN_CUF: begin
								e_col = (sum_c > (PW+1)'(COLS-1)) ? CW'(COLS-1) : CW'(sum_c);
							end
							ats_pkg::FIN_CUB: begin
								e_col = (par.v >= PW'(col_q)) ? '0 : col_q - CW'(par.v);
							end
							ats_pkg::FIN_CHA: begin
								e_col = CW'(ats_pkg::place(par.v, PW'(COLS)));
							end
							ats_pkg::FIN_VPA: begin
								e_row = RW'(ats_pkg::place(par.v, PW'(ROWS)));
							end
							ats_pkg::FIN_CUP, ats_pkg::FIN_HVP: begin
								e_row = RW'(ats_pkg::place(par.v, PW'(ROWS)));
								e_col = CW'(ats_pkg::place(par.w, PW'(COLS)));
							end
							ats_pkg::FIN_ED: begin
								if ((par.v0 == PW'(2)) || (par.v0 == PW'(3))) begin
									e_fa = '0;
									e_fe = AXW'(N-1);
									e_st = S_FILL;
									e_row = '0;
									e_col = '0;
								end else if (par.v0 == '0) begin
									e_fa = base + colx;
									e_fe = AXW'(N-1);
									e_st = S_FILL;
								end
							end
							ats_pkg::FIN_EL: begin
								e_st = S_FILL;
								if (par.v0 == PW'(2)) begin
									e_fa = base;
									e_fe = base + AXW'(COLS-1);
								end else if (par.v0 == PW'(1)) begin
									e_fa = base;
									e_fe = base + colx;
								end else begin
									e_fa = base + colx;
									e_fe = base + AXW'(COLS-1);
								end
							end
							ats_pkg::FIN_DCH: begin
								if (n != '0) begin
									e_cs = base + colx + AXW'(n);
									e_ce = base + AXW'(COLS-1);
									e_off = AXW'(n);
									e_fa = base + AXW'(COLS) - AXW'(n);
									e_fe = base + AXW'(COLS-1);
									e_st = (e_cs <= e_ce) ? S_COPY : S_FILL;
								end
							end
							ats_pkg::FIN_SCP: begin
								e_save = 1'b1;
							end
							ats_pkg::FIN_RCP: begin
								e_row = srow_q;
								e_col = scol_q;
							end
							default: begin
							end
						endcase
					end else begin
						pcmd.keep = 1'b1;
					end
				end
				default: begin
					e_mode = ats_pkg::MODE_GROUND;
					if (ch == ats_pkg::CH_ESC) begin
						e_mode = ats_pkg::MODE_ESC;
					end else if (ch == ats_pkg::CH_CR) begin
						e_col = '0;
					end else if (ch == ats_pkg::CH_LF) begin
						lf = 1'b1;
					end else if (ch == ats_pkg::CH_BS) begin
						if (col_q != '0) begin
							e_col = col_q - 1'b1;
						end
					end else if (ch == ats_pkg::CH_TAB) begin
						e_col = (tab > (CW+5)'(COLS-1)) ? CW'(COLS-1) : CW'(tab);
					end else if (ch >= ats_pkg::CH_SPACE) begin
						e_we = 1'b1;
						if (colinc >= (CW+1)'(COLS)) begin
							e_col = '0;
							lf = 1'b1;
						end else begin
							e_col = CW'(colinc);
						end
					end
				end
			endcase
		end
		// line feed, scrolling on the bottom row
		if (lf) begin
			if (row_q == RW'(ROWS-1)) begin
				e_cs = AXW'(COLS);
				e_ce = AXW'(N-1);
				e_off = AXW'(COLS);
				e_fa = AXW'(N-COLS);
				e_fe = AXW'(N-1);
				e_st = S_COPY;
			end else begin
				e_row = row_q + 1'b1;
			end
		end
		if (st_q != S_EXEC) begin
			pcmd.clear = 1'b0;
			pcmd.keep = 1'b0;
		end
	end

	// store port selection
	always_comb begin
		m_we = 1'b0;
		m_wa = '0;
		m_wd = ats_pkg::CH_SPACE;
		m_ra = '0;
		case (st_q)
			S_EXEC: begin
				m_we = e_we;
				m_wa = e_wa;
				m_wd = ch;
				m_ra = e_ra;
			end
			S_COPY: begin
				m_we = pend_s1;
				m_wa = cp_s1 - off_q;
				m_wd = rdata;
				m_ra = cp_q;
			end
			S_DRAIN: begin
				m_we = 1'b1;
				m_wa = cp_s1 - off_q;
				m_wd = rdata;
			end
			S_FILL: begin
				m_we = 1'b1;
				m_wa = fa_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_FILL;
			boot_q <= 1'b1;
			fa_q <= '0;
			fe_q <= AXW'(N-1);
			row_q <= '0;
			col_q <= '0;
			srow_q <= '0;
			scol_q <= '0;
			mode_q <= ats_pkg::MODE_GROUND;
			pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on a new result, cleared when taken
			if ((st_q == S_FIN) && (!out_valid_q || !rsp_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						cell_q <= '0;
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					row_q <= e_row;
					col_q <= e_col;
					mode_q <= e_mode;
					if (e_save) begin
						srow_q <= row_q;
						scol_q <= col_q;
					end
					cp_q <= e_cs;
					ce_q <= e_ce;
					off_q <= e_off;
					fa_q <= e_fa;
					fe_q <= e_fe;
					pend_s1 <= 1'b0;
					st_q <= e_st;
				end
				S_RD: begin
					cell_q <= rdata;
					st_q <= S_FIN;
				end
				S_COPY: begin
					cp_s1 <= cp_q;
					pend_s1 <= 1'b1;
					cp_q <= cp_q + 1'b1;
					if (cp_q == ce_q) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					pend_s1 <= 1'b0;
					st_q <= S_FILL;
				end
				S_FILL: begin
					fa_q <= fa_q + 1'b1;
					if (fa_q == fe_q) begin
						if (boot_q) begin
							boot_q <= 1'b0;
							st_q <= S_IDLE;
						end else begin
							st_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (!out_valid_q || !rsp_stall) begin
						out_q.cell_char <= cell_q;
						out_q.cursor_row <= 5'(row_q);
						out_q.cursor_col <= 7'(col_q);
						out_q.parse_mode <= mode_q;
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (st_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	`ATS_ASSERT_IMP(a_row_range, 1'b1, row_q <= RW'(ROWS-1))
	`ATS_ASSERT_IMP(a_copy_order, (st_q == S_COPY) && pend_s1, (cp_s1 - off_q) < cp_q)
	`ATS_ASSERT_NEXT(a_one_item, req_valid && !req_stall, st_q == S_EXEC)
endmodule
`default_nettype wire

// ----- verif/ansi_text_terminal_screen_tb.sv -----
// testbench for the ansi text terminal screen: drives bytes and cell reads,
// predicts the screen, cursor and parser mode and checks every result
// depends on ats_pkg and the ansi_text_terminal_screen rtl
module ansi_text_terminal_screen_tb;
	localparam int NR = ats_pkg::ROWS_DEF;
	localparam int NC = ats_pkg::COLS_DEF;

	// screen predictor and queue of expected results
	class screen_board;
		logic [7:0] cells [NR*NC];
		int crow, ccol, srow, scol, mode;
		int p1, p2, present, field, stopped, seqlen;
		ats_pkg::rsp_t pending [$];
		int fails, checked, reads;

		function void clear();
			foreach (cells[i]) cells[i] = ats_pkg::CH_SPACE;
			crow = 0; ccol = 0; srow = 0; scol = 0; mode = ats_pkg::MODE_GROUND;
			p1 = 0; p2 = 0; present = 0; field = 0; stopped = 0; seqlen = 0;
			fails = 0; checked = 0; reads = 0;
		endfunction

		function void blank(int r, int first, int last);
			for (int c = first; c <= last && c < NC; c++) cells[r*NC+c] = ats_pkg::CH_SPACE;
		endfunction

		function void down_line();
			crow++;
			if (crow < NR) return;
			for (int i = 0; i < (NR-1)*NC; i++) cells[i] = cells[i+NC];
			blank(NR-1, 0, NC-1);
			crow = NR-1;
		endfunction

		function int pos1(int v, int lim);
			int p;
			p = v > 0 ? v-1 : 0;
			return p < lim ? p : lim-1;
		endfunction

		function void run_seq(logic [7:0] fin);
			int v, v0, w, n;
			v = present[0] ? p1 : 1;
			v0 = present[0] ? p1 : 0;
			w = present[1] ? p2 : 1;
			case (fin)
				ats_pkg::FIN_CUU: crow = v >= crow ? 0 : crow - v;
				ats_pkg::FIN_CUD: crow = crow + v > NR-1 ? NR-1 : crow + v;
				ats_pkg::FIN_CUF: ccol = ccol + v > NC-1 ? NC-1 : ccol + v;
				ats_pkg::FIN_CUB: ccol = v >= ccol ? 0 : ccol - v;
				ats_pkg::FIN_CHA: ccol = pos1(v, NC);
				ats_pkg::FIN_VPA: crow = pos1(v, NR);
				ats_pkg::FIN_CUP, ats_pkg::FIN_HVP: begin
					crow = pos1(v, NR);
					ccol = pos1(w, NC);
				end
				ats_pkg::FIN_ED: begin
					if (v0 == 2 || v0 == 3) begin
						for (int r = 0; r < NR; r++) blank(r, 0, NC-1);
						crow = 0; ccol = 0;
					end else if (v0 == 0) begin
						blank(crow, ccol, NC-1);
						for (int r = crow+1; r < NR; r++) blank(r, 0, NC-1);
					end
				end
				ats_pkg::FIN_EL: begin
					if (v0 == 2) blank(crow, 0, NC-1);
					else if (v0 == 1) blank(crow, 0, ccol);
					else blank(crow, ccol, NC-1);
				end
				ats_pkg::FIN_DCH: begin
					n = NC - ccol;
					if (v < n) n = v;
					if (n != 0) begin
						for (int i = ccol; i + n < NC; i++)
							cells[crow*NC+i] = cells[crow*NC+i+n];
						blank(crow, NC-n, NC-1);
					end
				end
				ats_pkg::FIN_SCP: begin srow = crow; scol = ccol; end
				ats_pkg::FIN_RCP: begin crow = srow; ccol = scol; end
				default: ;
			endcase
		endfunction

		function void seq_byte(logic [7:0] ch);
			int nv;
			if (seqlen >= ats_pkg::SEQ_MAX_DEF) return;
			seqlen++;
			if (ch == ats_pkg::CH_SEMI) begin
				if (field < 2) field++;
				stopped = 0;
				return;
			end
			if (field >= 2) return;
			present |= 1 << field;
			if (stopped) return;
			if (ch >= ats_pkg::CH_ZERO && ch <= ats_pkg::CH_NINE) begin
				nv = (field == 0 ? p1 : p2) * 10 + (ch - ats_pkg::CH_ZERO);
				if (nv > ats_pkg::PARAM_LIMIT) nv = ats_pkg::PARAM_LIMIT;
				if (field == 0) p1 = nv; else p2 = nv;
			end else stopped = 1;
		endfunction

		function void take_byte(logic [7:0] ch);
			if (ch >= 8'h80) return;
			if (mode == ats_pkg::MODE_ESC) begin
				mode = ats_pkg::MODE_GROUND;
				if (ch == ats_pkg::CH_LBRACK) begin
					mode = ats_pkg::MODE_CSI;
					p1 = 0; p2 = 0; present = 0; field = 0; stopped = 0; seqlen = 0;
				end else if (ch == ats_pkg::CH_SEVEN) begin
					srow = crow; scol = ccol;
				end else if (ch == ats_pkg::CH_EIGHT) begin
					crow = srow; ccol = scol;
				end
				return;
			end
			if (mode == ats_pkg::MODE_CSI) begin
				if (ch >= ats_pkg::CSI_FIRST && ch <= ats_pkg::CSI_LAST) begin
					run_seq(ch);
					mode = ats_pkg::MODE_GROUND;
				end else seq_byte(ch);
				return;
			end
			if (ch == ats_pkg::CH_ESC) mode = ats_pkg::MODE_ESC;
			else if (ch == ats_pkg::CH_CR) ccol = 0;
			else if (ch == ats_pkg::CH_LF) down_line();
			else if (ch == ats_pkg::CH_BS) begin
				if (ccol > 0) ccol--;
			end else if (ch == ats_pkg::CH_TAB) begin
				ccol = (ccol / ats_pkg::TAB_WIDTH_DEF + 1) * ats_pkg::TAB_WIDTH_DEF;
				if (ccol > NC-1) ccol = NC-1;
			end else if (ch >= ats_pkg::CH_SPACE) begin
				cells[crow*NC+ccol] = ch;
				ccol++;
				if (ccol >= NC) begin
					ccol = 0;
					down_line();
				end
			end
		endfunction

		// note an accepted item and queue its expected result
		function void note_item(ats_pkg::req_t it);
			ats_pkg::rsp_t e;
			e.cell_char = 8'h00;
			if (!it.req_type) take_byte(it.data_byte);
			else begin
				reads++;
				if (it.read_row < NR && it.read_col < NC)
					e.cell_char = cells[it.read_row*NC + it.read_col];
			end
			e.cursor_row = crow[4:0];
			e.cursor_col = ccol[6:0];
			e.parse_mode = mode[1:0];
			pending.push_back(e);
		endfunction

		function void check_result(ats_pkg::rsp_t got);
			ats_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				fails++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.cell_char !== e.cell_char) begin
				$error("cell_char expected %0h got %0h", e.cell_char, got.cell_char); fails++;
			end
			if (got.cursor_row !== e.cursor_row) begin
				$error("cursor_row expected %0d got %0d", e.cursor_row, got.cursor_row); fails++;
			end
			if (got.cursor_col !== e.cursor_col) begin
				$error("cursor_col expected %0d got %0d", e.cursor_col, got.cursor_col); fails++;
			end
			if (got.parse_mode !== e.parse_mode) begin
				$error("parse_mode expected %0d got %0d", e.parse_mode, got.parse_mode); fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	ats_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ats_pkg::rsp_t rsp;
	int send_idle = 0;
	int recv_idle = 0;
	screen_board board;

	ansi_text_terminal_screen dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stall, check accepted results
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) board.check_result(rsp);
		rsp_stall <= ($urandom_range(99) < recv_idle);
	end

	// send one item, with random gaps before it; valid stays up for back to back items
	task automatic send(ats_pkg::req_t it);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_item(it);
	endtask

	task automatic put(logic [7:0] b);
		ats_pkg::req_t it;
		it = '0;
		it.data_byte = b;
		it.read_row = 5'($urandom);
		it.read_col = 7'($urandom);
		send(it);
	endtask

	task automatic peek(logic [4:0] r, logic [6:0] c);
		ats_pkg::req_t it;
		it = '0;
		it.req_type = 1'b1;
		it.data_byte = 8'($urandom);
		it.read_row = r;
		it.read_col = c;
		send(it);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// one random item, mostly well-formed sequences with random content
	task automatic random_item();
		logic [7:0] fins [13];
		int k;
		fins = '{ats_pkg::FIN_CUU, ats_pkg::FIN_CUD, ats_pkg::FIN_CUF, ats_pkg::FIN_CUB,
			ats_pkg::FIN_CHA, ats_pkg::FIN_VPA, ats_pkg::FIN_CUP, ats_pkg::FIN_HVP,
			ats_pkg::FIN_ED, ats_pkg::FIN_EL, ats_pkg::FIN_DCH, ats_pkg::FIN_SCP,
			ats_pkg::FIN_RCP};
		k = $urandom_range(99);
		if (k < 30) put(8'($urandom_range(8'h20, 8'h7E)));
		else if (k < 45) peek(5'($urandom_range(NR-1)), 7'($urandom_range(NC-1)));
		else if (k < 48) peek(5'($urandom), 7'($urandom));
		else if (k < 80) begin
			put(ats_pkg::CH_ESC);
			put(ats_pkg::CH_LBRACK);
			if ($urandom_range(3) != 0) begin
				if ($urandom_range(9) == 0) put_str($sformatf("%0d", $urandom_range(99999)));
				else put_str($sformatf("%0d", $urandom_range(30)));
			end
			if ($urandom_range(2) == 0) begin
				put(ats_pkg::CH_SEMI);
				if ($urandom_range(3) != 0) put_str($sformatf("%0d", $urandom_range(90)));
			end
			if ($urandom_range(9) == 0) put(8'($urandom_range(8'h20, 8'h3F)));
			if ($urandom_range(19) == 0) put(8'($urandom));
			// erase-all only rarely, so the screen keeps content
			k = $urandom_range(12);
			if (fins[k] == ats_pkg::FIN_ED && $urandom_range(3) != 0) k = 2;
			if ($urandom_range(9) == 0)
				put(8'($urandom_range(ats_pkg::CSI_FIRST, ats_pkg::CSI_LAST)));
			else put(fins[k]);
		end else if (k < 85) begin
			put(ats_pkg::CH_ESC);
			put($urandom_range(1) ? ats_pkg::CH_SEVEN : ats_pkg::CH_EIGHT);
		end else if (k < 93) begin
			case ($urandom_range(3))
				0: put(ats_pkg::CH_CR);
				1: put(ats_pkg::CH_LF);
				2: put(ats_pkg::CH_BS);
				default: put(ats_pkg::CH_TAB);
			endcase
		end else put(8'($urandom));
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: text, wrap, controls, escapes and every sequence
		put_str("Hi");
		put(8'hFF);
		put(8'h01);
		put(ats_pkg::CH_TAB); put(ats_pkg::CH_BS); put(ats_pkg::CH_CR); put(ats_pkg::CH_LF);
		put(ats_pkg::CH_ESC); put(8'h7F);
		put_str("\033[24;80H");
		put_str("~!");
		put_str("\0337\033[5;99999f\0338");
		put_str("\033[-5;3H\033[s\033[2A\033[9B\033[C\033[99D\033[0G\033[3d\033[u");
		put_str("\033[2P\033[K\033[1K\033[2K\033[J\033[5J\033[3J\033[z");
		put_str("\033[1;2;3;4;5;6;7;8;9;1;2;3;4;5;6;7;8;9;1;2;3;4;5;6;7;8;9H");
		peek(5'd0, 7'd0); peek(5'd23, 7'd79); peek(5'd31, 7'd127); peek(5'd24, 7'd0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = phase == 0 ? 34 : phase == 1 ? 81 : 0;
			recv_idle = phase == 0 ? 81 : phase == 1 ? 34 : 0;
			for (int i = 0; i < 50; i++) random_item();
			// hold the sender until every result is back
			drain();
			for (int i = 0; i < 100; i++) random_item();
		end
		drain();
		repeat (20) @(posedge clk);
		$display("checked %0d results, %0d cell reads, over three idling phases",
			board.checked, board.reads);
		if (board.fails == 0 && board.pending.size() == 0)
			$display("** ansi_text_terminal_screen: PASSED **");
		else
			$display("** ansi_text_terminal_screen: FAILED **");
		$finish;
	end

	// watchdog: each scroll copies the whole store
	initial begin
		#100000000;
		$display("** ansi_text_terminal_screen: FAILED **");
		$finish;
	end
endmodule
